### rtl/qma_pkg.sv
package qma_pkg;

  // Fixed grid: 64 x 64 finest cells, levels 0 (finest) to 6 (root)
  localparam int unsigned GRID_LOG2 = 6;
  localparam int unsigned TOP_LEVEL = GRID_LOG2;
  localparam int unsigned NODE_DEPTH = 5461;
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned LVL_W = 3;
  localparam int unsigned IDX_W = 6;
  localparam logic [19:0] MASS_MAX = 20'hFFFFF;

  // Register byte address on the configuration port
  localparam logic [2:0] ADDR_MASS = 3'd0;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_QUERY  = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // First memory address of each level
  localparam logic [ADDR_W-1:0] LEVEL_BASE [0:TOP_LEVEL] = '{
    13'd0, 13'd4096, 13'd5120, 13'd5376, 13'd5440, 13'd5456, 13'd5460
  };

  typedef struct packed {
    logic [IDX_W-1:0] cell_col;
    logic [IDX_W-1:0] cell_row;
    logic [19:0]      node_mass;
    logic [15:0]      center_x;
    logic [15:0]      center_y;
    logic             node_empty;
    logic             count_overflow;
  } result_t;

  // Address of node (col,row) at a level, given in level indexes
  function automatic logic [ADDR_W-1:0] node_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [IDX_W-1:0] col,
                                                  input logic [IDX_W-1:0] row);
    logic [ADDR_W-1:0] r;
    logic [ADDR_W-1:0] c;
    r = ADDR_W'(row) << (LVL_W'(GRID_LOG2) - lvl);
    c = ADDR_W'(col);
    return LEVEL_BASE[lvl] + r + c;
  endfunction

endpackage

### rtl/qma_div.sv
// Signed sum over unsigned count, truncated toward zero, two lanes, one bit a cycle
module qma_div #(
  parameter int unsigned SUM_W = 29,
  parameter int unsigned CNT_W = 13
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] num_x,
  input  logic signed [SUM_W-1:0] num_y,
  input  logic [CNT_W-1:0]        den,
  output logic                    done,
  output logic [15:0]             quo_x,
  output logic [15:0]             quo_y
);

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  qx_r, qy_r;
  logic [CNT_W:0]    remx_r, remy_r;
  logic [CNT_W-1:0]  den_r;
  logic              negx_r, negy_r;
  logic              done_r;
  logic [CNT_W:0]    trx, try_;
  logic              gex, gey;
  logic [15:0]       qlx, qly;

  // Shift in next dividend bit and trial subtract
  assign trx  = {remx_r[CNT_W-1:0], qx_r[SUM_W-1]};
  assign try_ = {remy_r[CNT_W-1:0], qy_r[SUM_W-1]};
  assign gex  = trx >= {1'b0, den_r};
  assign gey  = try_ >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qx_r   <= num_x[SUM_W-1] ? SUM_W'(-num_x) : num_x;
      qy_r   <= num_y[SUM_W-1] ? SUM_W'(-num_y) : num_y;
      negx_r <= num_x[SUM_W-1];
      negy_r <= num_y[SUM_W-1];
      remx_r <= '0;
      remy_r <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      remx_r <= gex ? trx - {1'b0, den_r} : trx;
      remy_r <= gey ? try_ - {1'b0, den_r} : try_;
      qx_r   <= {qx_r[SUM_W-2:0], gex};
      qy_r   <= {qy_r[SUM_W-2:0], gey};
    end
  end

  // Apply sign to the magnitude quotient
  assign qlx   = qx_r[15:0];
  assign qly   = qy_r[15:0];
  assign quo_x = negx_r ? 16'(-qlx) : qlx;
  assign quo_y = negy_r ? 16'(-qly) : qly;
  assign done  = done_r;

endmodule

### rtl/quadtree_mass_aggregator.sv
// Channel  | Dir | Contents
// in_*     | in  | request: tuser op, tdata position and query node
// out_*    | out | result of an insert or a query
// cfg_*    | in  | APB particle mass register at byte address 0
// An insert reads the root and, unless the root count shows the tree full, does a
// read-modify-write of one level a cycle through the single node memory. A query
// reads the node and, if it is not empty, runs the bit-serial divider for the centre.
// Reset and a clear request each clear the node memory, taking no request meanwhile.
// A result waits in the output register; the block stalls only if a second one is due.
module quadtree_mass_aggregator #(
  parameter int unsigned MAX_PARTICLES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // pos_x, pos_y, query_level, query_col, query_row, pad
  input  logic [1:0]  in_tuser,  // op
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_col, cell_row, node_mass, center_x, center_y, node_empty, count_overflow, pad
  output logic [71:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned SUM_W = 17 + $clog2(MAX_PARTICLES);
  localparam int unsigned ENT_W = CNT_W + 2 * SUM_W;
  localparam int unsigned PW    = CNT_W + 8;
  localparam int unsigned AW    = qma_pkg::ADDR_W;
  localparam int unsigned LW    = qma_pkg::LVL_W;
  localparam int unsigned IW    = qma_pkg::IDX_W;

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_ROOT  = 8'b0000_0100,
    S_INS   = 8'b0000_1000,
    S_QCHK  = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_OUT   = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration register
  logic [7:0] mass_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == qma_pkg::ADDR_MASS) ? {24'd0, mass_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mass_r <= 8'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == qma_pkg::ADDR_MASS) begin
      mass_r <= cfg_pwdata[7:0];
    end
  end

  // Request fields
  logic [15:0]   in_px, in_py;
  logic [LW-1:0] in_lvl, q_lvl;
  logic [IW-1:0] in_qc, in_qr, bin_c, bin_r;
  logic          in_acc, q_oor;
  assign in_px  = in_tdata[15:0];
  assign in_py  = in_tdata[31:16];
  assign in_lvl = in_tdata[34:32];
  assign in_qc  = in_tdata[40:35];
  assign in_qr  = in_tdata[46:41];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;

  // Bin: floor(v*64/8192) = v>>7, negative to 0, clamp to 63
  always_comb begin
    bin_c = in_px[15] ? '0 : (|in_px[14:13] ? '1 : in_px[12:7]);
    bin_r = in_py[15] ? '0 : (|in_py[14:13] ? '1 : in_py[12:7]);
    q_lvl = (in_lvl > LW'(qma_pkg::TOP_LEVEL)) ? LW'(qma_pkg::TOP_LEVEL) : in_lvl;
    q_oor = ((in_qc >> (LW'(qma_pkg::GRID_LOG2) - q_lvl)) != '0) ||
            ((in_qr >> (LW'(qma_pkg::GRID_LOG2) - q_lvl)) != '0);
  end

  // Node memory: {count, sum_x, sum_y}
  logic [ENT_W-1:0] mem [0:qma_pkg::NODE_DEPTH-1];
  logic [ENT_W-1:0] rdata_r, wdata;
  logic [AW-1:0]    raddr, waddr, clr_r;
  logic             we;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  logic [CNT_W-1:0]        r_cnt;
  logic signed [SUM_W-1:0] r_sx, r_sy, px_e, py_e;
  assign r_cnt = rdata_r[ENT_W-1 -: CNT_W];
  assign r_sx  = rdata_r[2*SUM_W-1 -: SUM_W];
  assign r_sy  = rdata_r[SUM_W-1:0];

  // Work registers
  logic [IW-1:0]    col_r, row_r;
  logic [15:0]      px_r, py_r;
  logic [LW-1:0]    lvl_r;
  logic [CNT_W-1:0] qcnt_r;
  qma_pkg::result_t res_r, out_r;
  logic             out_valid_r;
  assign px_e = {{(SUM_W-16){px_r[15]}}, px_r};
  assign py_e = {{(SUM_W-16){py_r[15]}}, py_r};

  // Mass with saturation
  logic [PW-1:0]    prod;
  logic [PW+19:0]   prod_ext;
  logic [19:0]      mass_sat;
  assign prod     = PW'(r_cnt) * PW'(mass_r);
  assign prod_ext = {20'd0, prod};
  assign mass_sat = (prod_ext > (PW+20)'(qma_pkg::MASS_MAX)) ? qma_pkg::MASS_MAX
                                                             : prod_ext[19:0];

  // Divider
  logic        div_start, div_done;
  logic [15:0] qx, qy;
  qma_div #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num_x(r_sx), .num_y(r_sy), .den(r_cnt),
    .done(div_done), .quo_x(qx), .quo_y(qy)
  );

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // Next state, memory port control
  always_comb begin
    state_nxt = state_r;
    raddr     = qma_pkg::node_addr(lvl_r, col_r >> lvl_r, row_r >> lvl_r);
    waddr     = qma_pkg::node_addr(lvl_r, col_r >> lvl_r, row_r >> lvl_r);
    wdata     = {r_cnt + 1'b1, r_sx + px_e, r_sy + py_e};
    we        = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_CLR: begin
        waddr = clr_r;
        wdata = '0;
        we    = 1'b1;
        if (clr_r == AW'(qma_pkg::NODE_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            qma_pkg::OP_INSERT: begin
              raddr     = qma_pkg::LEVEL_BASE[qma_pkg::TOP_LEVEL];
              state_nxt = S_ROOT;
            end
            qma_pkg::OP_QUERY: begin
              raddr     = qma_pkg::node_addr(q_lvl, in_qc, in_qr);
              state_nxt = q_oor ? S_OUT : S_QCHK;
            end
            qma_pkg::OP_CLEAR: state_nxt = S_CLR;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ROOT: begin
        raddr     = qma_pkg::LEVEL_BASE[0] + AW'({row_r, col_r});
        state_nxt = (r_cnt >= CNT_W'(MAX_PARTICLES)) ? S_OUT : S_INS;
      end
      S_INS: begin
        we = 1'b1;
        if (lvl_r == LW'(qma_pkg::TOP_LEVEL)) begin
          state_nxt = S_OUT;
        end else begin
          raddr = qma_pkg::node_addr(lvl_r + 1'b1, col_r >> (lvl_r + 1'b1),
                                     row_r >> (lvl_r + 1'b1));
        end
      end
      S_QCHK: begin
        if (r_cnt == '0) begin
          state_nxt = S_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: if (div_done) state_nxt = S_OUT;
      S_OUT: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + 1'b1;
      else                  clr_r <= '0;
      if (state_r == S_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_tready)              out_valid_r <= 1'b0;
    end
  end

  // Payload and result building
  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) out_r <= res_r;
    case (state_r)
      S_IDLE: begin
        lvl_r <= '0;
        if (in_acc) begin
          col_r <= bin_c;
          row_r <= bin_r;
          px_r  <= in_px;
          py_r  <= in_py;
          res_r <= '{cell_col: (in_tuser == qma_pkg::OP_INSERT) ? bin_c : '0,
                     cell_row: (in_tuser == qma_pkg::OP_INSERT) ? bin_r : '0,
                     node_empty: (in_tuser == qma_pkg::OP_QUERY) && q_oor,
                     default: '0};
        end
      end
      S_ROOT: res_r.count_overflow <= (r_cnt >= CNT_W'(MAX_PARTICLES));
      S_INS: if (lvl_r != LW'(qma_pkg::TOP_LEVEL)) lvl_r <= lvl_r + 1'b1;
      S_QCHK: begin
        qcnt_r <= r_cnt;
        res_r.node_empty <= (r_cnt == '0);
        res_r.node_mass  <= mass_sat;
      end
      S_DIV: if (div_done) begin
        res_r.center_x <= qx;
        res_r.center_y <= qy;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.count_overflow, out_r.node_empty, out_r.center_y,
                       out_r.center_x, out_r.node_mass, out_r.cell_row, out_r.cell_col};

  // No request is taken during a clearing pass
  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_tready) else $error("request taken while clearing");
  // Divider finishes only while a query waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("stray divider completion");
  // A query never writes the node memory
  a_q_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QCHK || state_r == S_DIV) |-> !we) else $error("query wrote memory");
  // An empty node result never carries a mass
  a_empty_mass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_r.node_empty |-> out_r.node_mass == 20'd0)
    else $error("empty node with mass");
  // Division only starts on a non-empty node
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> qcnt_r != '0) else $error("divide by zero count");

endmodule
